>>> design/imucaf_pkg.sv
// Package for the IMU complementary attitude filter.
// Types, fixed widths, blend constants, saturation and the CORDIC arctangent table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package imucaf_pkg;

	localparam int ACC_W   = 56;
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int XY_W    = 28;
	localparam int Z_W     = 26;
	localparam int DEG_W   = 10;

	localparam logic [MUL_B_W-1:0] BLEND_KEEP  = 18'd65208;
	localparam logic [MUL_B_W-1:0] BLEND_ACC   = 18'd328;
	localparam logic [MUL_B_W-1:0] SMOOTH_KEEP = 18'd58982;
	localparam logic [MUL_B_W-1:0] SMOOTH_NEW  = 18'd6554;

	typedef struct packed {
		logic [15:0] gyro_x;
		logic [15:0] gyro_y;
		logic [15:0] gyro_z;
		logic [15:0] accel_x;
		logic [15:0] accel_y;
		logic [15:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic [15:0] pitch_out;
		logic [15:0] roll_out;
		logic [21:0] yaw_out;
	} result_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sd2147483647);
		lo = -hi - ACC_W'(64'sd1);
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [22:0] atan_q16(input logic [4:0] i);
		case (i)
			5'd0: return 23'd2949120;
			5'd1: return 23'd1740967;
			5'd2: return 23'd919879;
			5'd3: return 23'd466945;
			5'd4: return 23'd234379;
			5'd5: return 23'd117304;
			5'd6: return 23'd58666;
			5'd7: return 23'd29335;
			5'd8: return 23'd14668;
			5'd9: return 23'd7334;
			5'd10: return 23'd3667;
			5'd11: return 23'd1833;
			5'd12: return 23'd917;
			5'd13: return 23'd458;
			5'd14: return 23'd229;
			5'd15: return 23'd115;
			5'd16: return 23'd57;
			5'd17: return 23'd29;
			5'd18: return 23'd14;
			5'd19: return 23'd7;
			5'd20: return 23'd4;
			5'd21: return 23'd2;
			5'd22: return 23'd1;
			default: return 23'd0;
		endcase
	endfunction

endpackage

>>> design/imucaf_front.sv
// Front end: two-beat sample queue between the input port and the back end.
// Depends on imucaf_pkg for the sample type.
`timescale 1ns / 1ps

module imucaf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  imucaf_pkg::sample_t din,
	output logic               avail,
	output imucaf_pkg::sample_t dout,
	input  logic               take
);

	imucaf_pkg::sample_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_take;

	assign full    = (cnt_q == 2'd2);
	assign avail   = (cnt_q != 2'd0);
	assign dout    = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_take = take && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_take) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_take);
		end
	end

endmodule

>>> design/imucaf_back.sv
// Back end: sequencer with one shared multiplier, bit-serial square root and CORDIC.
// Holds the attitude state; depends on imucaf_pkg.
`timescale 1ns / 1ps

module imucaf_back #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         time_step,
	input  logic                in_avail,
	input  imucaf_pkg::sample_t in_data,
	output logic                in_take,
	output logic                res_valid,
	output imucaf_pkg::result_t res_data,
	input  logic                res_take
);

	localparam int ACC_W = imucaf_pkg::ACC_W;
	localparam int AW    = imucaf_pkg::MUL_A_W;
	localparam int BW    = imucaf_pkg::MUL_B_W;
	localparam int PW    = imucaf_pkg::MUL_P_W;
	localparam int XW    = imucaf_pkg::XY_W;
	localparam int ZW    = imucaf_pkg::Z_W;
	localparam int DW    = imucaf_pkg::DEG_W;
	localparam int SH_R  = (ANGLE_FRAC_BITS <= 22) ? 22 - ANGLE_FRAC_BITS : 0;
	localparam int SH_L  = (ANGLE_FRAC_BITS > 22) ? ANGLE_FRAC_BITS - 22 : 0;
	localparam int SH_O  = ANGLE_FRAC_BITS - 6;
	localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_GMUL  = 12'b000000000010,
		ST_GACC  = 12'b000000000100,
		ST_SQA   = 12'b000000001000,
		ST_SQB   = 12'b000000010000,
		ST_SQC   = 12'b000000100000,
		ST_SQRT  = 12'b000001000000,
		ST_CINIT = 12'b000010000000,
		ST_CRUN  = 12'b000100000000,
		ST_CDONE = 12'b001000000000,
		ST_MA    = 12'b010000000000,
		ST_MB    = 12'b100000000000
	} state_t;

	state_t state_q;
	logic   mc_q;
	logic   out_q;

	imucaf_pkg::sample_t smp_q;
	logic signed [31:0] gpa_q, gra_q, yaw_q, ps_q, rs_q;
	logic               started_q;
	logic [1:0]         k_q;
	logic [4:0]         cnt_q;
	logic               pass_q;
	logic signed [PW-1:0]   mul_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [30:0]        sq_q;
	logic [47:0]        rad_q;
	logic [23:0]        root_q;
	logic [25:0]        rem_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [DW-1:0] apd_q, ard_q;

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [ACC_W-1:0] inc;
	logic signed [31:0] gsel;
	logic signed [15:0] rsel;
	logic [27:0] trial_hi, trial_sub;
	logic signed [XW-1:0] cx, cy, dx, dy;
	logic signed [ZW-1:0] cz, zsh;
	logic signed [DW-1:0] deg;
	logic signed [DW-1:0] kdeg;
	logic signed [ACC_W-1:0] mres;
	logic signed [31:0] po, ro, yo;

	always_comb begin
		case (k_q)
			2'd0: rsel = $signed(smp_q.gyro_y);
			2'd1: rsel = $signed(smp_q.gyro_x);
			default: rsel = $signed(smp_q.gyro_z);
		endcase
		case (k_q)
			2'd0: gsel = gpa_q;
			2'd1: gsel = gra_q;
			default: gsel = yaw_q;
		endcase
		kdeg = (k_q == 2'd0) ? apd_q : ard_q;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_GMUL: begin
				mul_a = AW'(rsel);
				mul_b = $signed({2'b00, time_step});
			end
			ST_SQA: begin
				mul_a = AW'($signed(smp_q.accel_y));
				mul_b = BW'($signed(smp_q.accel_y));
			end
			ST_SQB: begin
				mul_a = AW'($signed(smp_q.accel_z));
				mul_b = BW'($signed(smp_q.accel_z));
			end
			ST_MA: begin
				case (k_q)
					2'd0: begin
						mul_a = AW'(gpa_q);
						mul_b = $signed(imucaf_pkg::BLEND_KEEP);
					end
					2'd1: begin
						mul_a = AW'(gra_q);
						mul_b = $signed(imucaf_pkg::BLEND_KEEP);
					end
					2'd2: begin
						mul_a = AW'(ps_q);
						mul_b = $signed(imucaf_pkg::SMOOTH_KEEP);
					end
					default: begin
						mul_a = AW'(rs_q);
						mul_b = $signed(imucaf_pkg::SMOOTH_KEEP);
					end
				endcase
			end
			ST_MB: begin
				case (k_q)
					2'd0, 2'd1: begin
						mul_a = AW'(kdeg) <<< ANGLE_FRAC_BITS;
						mul_b = $signed(imucaf_pkg::BLEND_ACC);
					end
					2'd2: begin
						mul_a = AW'(gpa_q);
						mul_b = $signed(imucaf_pkg::SMOOTH_NEW);
					end
					default: begin
						mul_a = AW'(gra_q);
						mul_b = $signed(imucaf_pkg::SMOOTH_NEW);
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign inc = (ACC_W'(mul_q) >>> SH_R) <<< SH_L;
	assign mres = (acc_q + ACC_W'(mul_q) + ACC_W'(32768)) >>> 16;

	assign trial_hi  = {rem_q, rad_q[47:46]};
	assign trial_sub = {2'b00, root_q, 2'b01};

	assign dx  = y_q >>> cnt_q;
	assign dy  = x_q >>> cnt_q;
	assign zsh = z_q >>> 16;
	assign deg = zsh[DW-1:0] + DW'((z_q[ZW-1] && (z_q[15:0] != 16'd0)) ? 1 : 0);

	always_comb begin
		if (pass_q == 1'b0) begin
			cy = XW'($signed({smp_q.accel_x, 8'h00}));
			cx = XW'($signed({1'b0, root_q}));
		end else begin
			cy = XW'($signed(smp_q.accel_y));
			cx = XW'($signed(smp_q.accel_z));
		end
		cz = '0;
	end

	assign in_take   = (state_q == ST_IDLE) && !mc_q && !out_q && in_avail;
	assign res_valid = out_q;

	assign po = ps_q >>> SH_O;
	assign ro = rs_q >>> SH_O;
	assign yo = yaw_q >>> SH_O;

	always_comb begin
		if (po > 32'sd32767) begin
			res_data.pitch_out = 16'h7fff;
		end else if (po < -32'sd32768) begin
			res_data.pitch_out = 16'h8000;
		end else begin
			res_data.pitch_out = po[15:0];
		end
		if (ro > 32'sd32767) begin
			res_data.roll_out = 16'h7fff;
		end else if (ro < -32'sd32768) begin
			res_data.roll_out = 16'h8000;
		end else begin
			res_data.roll_out = ro[15:0];
		end
		if (yo > 32'sd2097151) begin
			res_data.yaw_out = 22'h1fffff;
		end else if (yo < -32'sd2097152) begin
			res_data.yaw_out = 22'h200000;
		end else begin
			res_data.yaw_out = yo[21:0];
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= PW'(mul_a * mul_b);
		if (in_take) begin
			smp_q <= in_data;
		end
		case (state_q)
			ST_SQB: sq_q <= mul_q[30:0];
			ST_SQC: begin
				rad_q  <= {32'(sq_q) + 32'(mul_q[30:0]), 16'h0000};
				root_q <= '0;
				rem_q  <= '0;
			end
			ST_SQRT: begin
				rad_q <= {rad_q[45:0], 2'b00};
				if (trial_hi >= trial_sub) begin
					rem_q  <= 26'(trial_hi - trial_sub);
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q  <= trial_hi[25:0];
					root_q <= {root_q[22:0], 1'b0};
				end
			end
			ST_CINIT: begin
				x_q <= cx;
				y_q <= cy;
				z_q <= cz;
				if (cy == '0) begin
					z_q <= cx[XW-1] ? ZW'(180 * 65536) : '0;
				end else if (cx == '0) begin
					z_q <= cy[XW-1] ? -ZW'(90 * 65536) : ZW'(90 * 65536);
				end else if (cx[XW-1]) begin
					if (!cy[XW-1]) begin
						x_q <= cy;
						y_q <= -cx;
						z_q <= ZW'(90 * 65536);
					end else begin
						x_q <= -cy;
						y_q <= cx;
						z_q <= -ZW'(90 * 65536);
					end
				end
			end
			ST_CRUN: begin
				if (!y_q[XW-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + ZW'(imucaf_pkg::atan_q16(cnt_q));
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - ZW'(imucaf_pkg::atan_q16(cnt_q));
				end
			end
			ST_CDONE: begin
				if (pass_q == 1'b0) begin
					apd_q <= -deg;
				end else begin
					ard_q <= deg;
				end
			end
			ST_MB: acc_q <= ACC_W'(mul_q);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mc_q      <= 1'b0;
			out_q     <= 1'b0;
			gpa_q     <= '0;
			gra_q     <= '0;
			yaw_q     <= '0;
			ps_q      <= '0;
			rs_q      <= '0;
			started_q <= 1'b0;
			k_q       <= '0;
			cnt_q     <= '0;
			pass_q    <= 1'b0;
		end else if (out_q) begin
			if (res_take) begin
				out_q <= 1'b0;
			end
		end else if (mc_q) begin
			mc_q  <= 1'b0;
			k_q   <= k_q + 2'd1;
			case (k_q)
				2'd0: gpa_q <= imucaf_pkg::sat32(mres);
				2'd1: gra_q <= imucaf_pkg::sat32(mres);
				2'd2: ps_q  <= imucaf_pkg::sat32(mres);
				default: rs_q <= imucaf_pkg::sat32(mres);
			endcase
			if (k_q == 2'd3) begin
				started_q <= 1'b1;
				out_q     <= 1'b1;
				state_q   <= ST_IDLE;
			end else begin
				state_q <= ST_MA;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_avail) begin
						k_q     <= '0;
						state_q <= ST_GMUL;
					end
				end
				ST_GMUL: state_q <= ST_GACC;
				ST_GACC: begin
					case (k_q)
						2'd0: gpa_q <= imucaf_pkg::sat32(ACC_W'(gsel) + inc);
						2'd1: gra_q <= imucaf_pkg::sat32(ACC_W'(gsel) + inc);
						default: yaw_q <= imucaf_pkg::sat32(ACC_W'(gsel) + inc);
					endcase
					if (k_q == 2'd2) begin
						state_q <= ST_SQA;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_GMUL;
					end
				end
				ST_SQA: state_q <= ST_SQB;
				ST_SQB: state_q <= ST_SQC;
				ST_SQC: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd23) begin
						pass_q  <= 1'b0;
						state_q <= ST_CINIT;
					end
				end
				ST_CINIT: begin
					cnt_q <= '0;
					if (cy == '0 || cx == '0) begin
						state_q <= ST_CDONE;
					end else begin
						state_q <= ST_CRUN;
					end
				end
				ST_CRUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(NSTEP - 1)) begin
						state_q <= ST_CDONE;
					end
				end
				ST_CDONE: begin
					if (pass_q == 1'b0) begin
						pass_q  <= 1'b1;
						state_q <= ST_CINIT;
					end else begin
						k_q     <= '0;
						state_q <= ST_MA;
					end
				end
				ST_MA: begin
					if (k_q[1] == 1'b0 && !started_q) begin
						if (k_q == 2'd0) begin
							gpa_q <= imucaf_pkg::sat32(ACC_W'(kdeg) <<< ANGLE_FRAC_BITS);
						end else begin
							gra_q <= imucaf_pkg::sat32(ACC_W'(kdeg) <<< ANGLE_FRAC_BITS);
						end
						k_q <= k_q + 2'd1;
					end else begin
						state_q <= ST_MB;
					end
				end
				ST_MB: begin
					mc_q    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> design/imucaf_top_out.sv
// Result holding register: one beat of output storage in front of the pop side.
// Depends on imucaf_pkg for the result type.
`timescale 1ns / 1ps

module imucaf_top_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  imucaf_pkg::result_t res_data,
	output logic                res_take,
	output logic                empty,
	input  logic                pop,
	output imucaf_pkg::result_t dout
);

	logic vld_q;
	imucaf_pkg::result_t data_q;

	assign res_take = res_valid && (!vld_q || pop);
	assign empty    = !vld_q;
	assign dout     = data_q;

	always_ff @(posedge clk) begin
		if (res_take) begin
			data_q <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_take) begin
			vld_q <= 1'b1;
		end else if (pop) begin
			vld_q <= 1'b0;
		end
	end

endmodule

>>> design/imu_complementary_attitude_filter.sv
// Top level of the IMU complementary attitude filter.
// Instantiates imucaf_front, imucaf_back and imucaf_top_out; uses imucaf_pkg.
//
// Push one IMU sample (three gyro rates, three accel axes) per beat; pop one attitude
// result (pitch, roll, yaw in 1/64 degree) per sample, in order. Samples are worked one
// at a time by a sequencer with a single shared multiplier, through a bit-serial square
// root and two CORDIC passes. Up to two samples queue ahead and two results wait
// behind. Write time_step only while no sample is in flight.
`timescale 1ns / 1ps

module imu_complementary_attitude_filter #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        time_step_we,
	input  logic [15:0] time_step,
	input  logic        push,
	output logic        full,
	input  logic [15:0] gyro_x,
	input  logic [15:0] gyro_y,
	input  logic [15:0] gyro_z,
	input  logic [15:0] accel_x,
	input  logic [15:0] accel_y,
	input  logic [15:0] accel_z,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] pitch_out,
	output logic [15:0] roll_out,
	output logic [21:0] yaw_out
);

	logic [15:0] ts_q;
	imucaf_pkg::sample_t din, qdata;
	imucaf_pkg::result_t rdata, odata;
	logic qavail, qtake, rvalid, rtake;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= 16'd262;
		end else if (time_step_we) begin
			ts_q <= time_step;
		end
	end

	assign din.gyro_x  = gyro_x;
	assign din.gyro_y  = gyro_y;
	assign din.gyro_z  = gyro_z;
	assign din.accel_x = accel_x;
	assign din.accel_y = accel_y;
	assign din.accel_z = accel_z;

	imucaf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.din    (din),
		.avail  (qavail),
		.dout   (qdata),
		.take   (qtake)
	);

	imucaf_back #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.CORDIC_STEPS    (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.time_step (ts_q),
		.in_avail  (qavail),
		.in_data   (qdata),
		.in_take   (qtake),
		.res_valid (rvalid),
		.res_data  (rdata),
		.res_take  (rtake)
	);

	imucaf_top_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (rvalid),
		.res_data  (rdata),
		.res_take  (rtake),
		.empty     (empty),
		.pop       (pop),
		.dout      (odata)
	);

	assign pitch_out = odata.pitch_out;
	assign roll_out  = odata.roll_out;
	assign yaw_out   = odata.yaw_out;

endmodule

>>> bench/tb_imu_complementary_attitude_filter.sv
// Self-checking bench for imu_complementary_attitude_filter: directed and random IMU samples,
// time_step swept across phases, with random push gaps and pop stalls.
// Depends on imucaf_pkg (sample_t, result_t) and the design sources.
`timescale 1ns / 1ps

module tb_imu_complementary_attitude_filter;

	class attitude_scoreboard;
		logic [15:0] step;
		longint gyro_pitch, gyro_roll, yaw, pitch_sm, roll_sm;
		bit started;
		imucaf_pkg::result_t pending[$];

		function new();
			step = 16'd262;
			gyro_pitch = 0;
			gyro_roll = 0;
			yaw = 0;
			pitch_sm = 0;
			roll_sm = 0;
			started = 0;
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint rate_increment(longint rate);
			return (rate * longint'({48'd0, step})) >>> 6;
		endfunction

		function longint int_sqrt(longint unsigned n);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n = n - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return longint'(res);
		endfunction

		function longint angle_deg(longint y, longint x);
			longint z, t, dx, dy;
			longint arctan[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
				58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
			z = 0;
			if (y == 0) return (x < 0) ? 180 : 0;
			if (x == 0) return (y > 0) ? 90 : -90;
			if (x < 0) begin
				if (y > 0) begin
					t = x; x = y; y = -t; z = 90 * 65536;
				end else begin
					t = x; x = -y; y = t; z = -90 * 65536;
				end
			end
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += arctan[i];
				end else begin
					x -= dx; y += dy; z -= arctan[i];
				end
			end
			return z / 65536;
		endfunction

		function logic [21:0] to_field(longint v, int w);
			longint hi;
			hi = (64'sd1 <<< (w - 1)) - 1;
			v = v >>> 10;
			if (v > hi) v = hi;
			if (v < -hi - 1) v = -hi - 1;
			return v[21:0];
		endfunction

		function void note_sample(imucaf_pkg::sample_t s);
			longint gx, gy, gz, ax, ay, az, gp, gr, mag, acc_pitch, acc_roll;
			imucaf_pkg::result_t r;
			gx = longint'($signed(s.gyro_x));
			gy = longint'($signed(s.gyro_y));
			gz = longint'($signed(s.gyro_z));
			ax = longint'($signed(s.accel_x));
			ay = longint'($signed(s.accel_y));
			az = longint'($signed(s.accel_z));
			gp = sat32(gyro_pitch + rate_increment(gy));
			gr = sat32(gyro_roll + rate_increment(gx));
			yaw = sat32(yaw + rate_increment(gz));
			mag = int_sqrt(longint'(ay * ay + az * az) << 16);
			acc_pitch = -angle_deg(ax * 256, mag) * 65536;
			acc_roll = angle_deg(ay, az) * 65536;
			if (started) begin
				gp = (gp * 65208 + acc_pitch * 328 + 32768) >>> 16;
				gr = (gr * 65208 + acc_roll * 328 + 32768) >>> 16;
			end else begin
				gp = acc_pitch;
				gr = acc_roll;
				started = 1;
			end
			gyro_pitch = sat32(gp);
			gyro_roll = sat32(gr);
			pitch_sm = sat32((pitch_sm * 58982 + gyro_pitch * 6554 + 32768) >>> 16);
			roll_sm = sat32((roll_sm * 58982 + gyro_roll * 6554 + 32768) >>> 16);
			r.pitch_out = 16'(to_field(pitch_sm, 16));
			r.roll_out = 16'(to_field(roll_sm, 16));
			r.yaw_out = to_field(yaw, 22);
			pending.push_back(r);
		endfunction

		function string check(imucaf_pkg::result_t got);
			imucaf_pkg::result_t e;
			string msg;
			if (pending.size() == 0) return "result beat with no sample pending";
			e = pending.pop_front();
			msg = "";
			if (got.pitch_out !== e.pitch_out)
				msg = {msg, $sformatf(" pitch %0d exp %0d", $signed(got.pitch_out),
					$signed(e.pitch_out))};
			if (got.roll_out !== e.roll_out)
				msg = {msg, $sformatf(" roll %0d exp %0d", $signed(got.roll_out),
					$signed(e.roll_out))};
			if (got.yaw_out !== e.yaw_out)
				msg = {msg, $sformatf(" yaw %0d exp %0d", $signed(got.yaw_out),
					$signed(e.yaw_out))};
			return msg;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        time_step_we;
	logic [15:0] time_step;
	logic        push;
	logic        full;
	logic [15:0] gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z;
	logic        empty;
	logic        pop;
	logic [15:0] pitch_out, roll_out;
	logic [21:0] yaw_out;

	attitude_scoreboard sb;
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	imu_complementary_attitude_filter dut (
		.clk(clk), .arst_n(arst_n), .time_step_we(time_step_we), .time_step(time_step),
		.push(push), .full(full), .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .empty(empty),
		.pop(pop), .pitch_out(pitch_out), .roll_out(roll_out), .yaw_out(yaw_out)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report(string msg);
		errors++;
		$display("%0t mismatch:%s", $realtime, msg);
	endtask

	// check each popped beat, then pick the next pop
	initial begin
		imucaf_pkg::result_t r;
		string msg;
		pop = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				r.pitch_out = pitch_out;
				r.roll_out = roll_out;
				r.yaw_out = yaw_out;
				msg = sb.check(r);
				if (msg != "") report(msg);
			end
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(imucaf_pkg::sample_t s);
		while ($urandom_range(99) < idle_pct) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		gyro_x <= s.gyro_x;
		gyro_y <= s.gyro_y;
		gyro_z <= s.gyro_z;
		accel_x <= s.accel_x;
		accel_y <= s.accel_y;
		accel_z <= s.accel_z;
		do @(posedge clk); while (full);
		sb.note_sample(s);
	endtask

	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_step(logic [15:0] v);
		time_step_we <= 1;
		time_step <= v;
		@(posedge clk);
		time_step_we <= 0;
		sb.step = v;
		@(posedge clk);
	endtask

	function automatic logic [15:0] accel_value();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'($signed($urandom_range(40)) - 20);
			2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic imucaf_pkg::sample_t random_sample(int bias);
		imucaf_pkg::sample_t s;
		s.gyro_x = 16'($urandom);
		s.gyro_y = 16'($urandom);
		s.gyro_z = 16'($urandom);
		if (bias == 1) begin
			s.gyro_x = 16'($urandom_range(32767));
			s.gyro_y = 16'($urandom_range(32767));
			s.gyro_z = 16'($urandom_range(32767));
		end else if (bias == 2) begin
			s.gyro_x = 16'h8000 | 16'($urandom);
			s.gyro_y = 16'h8000 | 16'($urandom);
			s.gyro_z = 16'h8000 | 16'($urandom);
		end
		s.accel_x = accel_value();
		s.accel_y = accel_value();
		s.accel_z = accel_value();
		return s;
	endfunction

	initial begin
		imucaf_pkg::sample_t s;
		logic [15:0] steps[4] = '{16'd1, 16'd65535, 16'd0, 16'd262};
		int idles[4] = '{0, 66, 0, 19};
		int stalls[4] = '{0, 0, 66, 19};
		sb = new();
		arst_n = 0;
		time_step_we = 0;
		time_step = 0;
		push = 0;
		{gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z} = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: exact axes, field extremes, first-sample load at reset step
		s = '{16'd100, 16'hff00, 16'd5, 16'd0, 16'd0, 16'd1000};
		send(s);
		s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hfc18};
		send(s);
		s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd500, 16'd0};
		send(s);
		s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'hfe0c, 16'd0};
		send(s);
		s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		send(s);
		s = '{16'd0, 16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0};
		send(s);
		s = '{16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0};
		send(s);
		s = '{16'd0, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000};
		send(s);
		s = '{16'd0, 16'd0, 16'd0, 16'h7fff, 16'h7fff, 16'h7fff};
		send(s);
		s = '{16'd0, 16'd0, 16'd0, 16'd3, 16'h8000, 16'h7fff};
		send(s);
		s = '{16'd0, 16'd0, 16'd0, 16'hfffd, 16'h7fff, 16'h8000};
		send(s);
		drain();
		write_step(16'd65535);
		for (int i = 0; i < 8; i++) begin
			s = '{16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 16'd0, 16'd1};
			send(s);
		end
		for (int i = 0; i < 8; i++) begin
			s = '{16'h8000, 16'h8000, 16'h8000, 16'd10, 16'hfff0, 16'hffff};
			send(s);
		end
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_step(steps[ph]);
			idle_pct = idles[ph];
			stall_pct = stalls[ph];
			for (int i = 0; i < 470; i++) begin
				if (i % 100 == 0) begin
					idle_pct = (i % 200 == 0) ? idles[ph] : 0;
					stall_pct = (i % 200 == 0) ? stalls[ph] : 0;
				end
				send(random_sample((i / 60) % 3));
			end
			drain();
		end
		write_step(16'($urandom_range(65535, 1)));
		for (int i = 0; i < 20; i++) send(random_sample(0));
		drain();

		if (sb.pending.size() != 0) report("samples left without a result");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
